/* sv/fpalu_pkg.sv */
// Shared types, constants and helpers for the fixed-point ALU.
package fpalu_pkg;

   localparam int DATA_W        = 32;
   localparam int FRAC_BITS_DEF = 8;
   localparam int FRAC_BITS_MAX = 16;

   localparam logic [DATA_W-1:0] MAX_RAW = 32'h7fff_ffff;
   localparam logic [DATA_W-1:0] MIN_RAW = 32'h8000_0000;

   typedef enum logic [3:0] {
      OP_ADD      = 4'd0,
      OP_SUB      = 4'd1,
      OP_MUL      = 4'd2,
      OP_DIV      = 4'd3,
      OP_GT       = 4'd4,
      OP_LT       = 4'd5,
      OP_GE       = 4'd6,
      OP_LE       = 4'd7,
      OP_NE       = 4'd8,
      OP_EQ       = 4'd9,
      OP_MIN      = 4'd10,
      OP_MAX      = 4'd11,
      OP_INC      = 4'd12,
      OP_DEC      = 4'd13,
      OP_TO_INT   = 4'd14,
      OP_FROM_INT = 4'd15
   } opcode_type;

   // Clamp a 33-bit signed sum to 32 bits; the top bit of the return is the overflow flag
   function automatic logic [DATA_W:0] sat_sum(logic [DATA_W:0] s);
      logic [DATA_W:0] r;
      if (s[DATA_W] != s[DATA_W-1]) begin
         r = {1'b1, (s[DATA_W] ? MIN_RAW : MAX_RAW)};
      end else begin
         r = {1'b0, s[DATA_W-1:0]};
      end
      return r;
   endfunction

endpackage

/* sv/fpalu_ifs.sv */
// Request and response channel interfaces of the fixed-point ALU.
interface fpalu_req_if import fpalu_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [3:0]               opcode;
   logic signed [DATA_W-1:0] operand_a;
   logic signed [DATA_W-1:0] operand_b;

   modport source (output valid, output opcode, output operand_a, output operand_b,
                   input ready);
   modport sink   (input valid, input opcode, input operand_a, input operand_b,
                   output ready);
endinterface

interface fpalu_rsp_if import fpalu_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] result_value;
   logic                     compare_true;
   logic                     error_flag;

   modport source (output valid, output result_value, output compare_true,
                   output error_flag, input ready);
   modport sink   (input valid, input result_value, input compare_true,
                   input error_flag, output ready);
endinterface

/* sv/fixed_point_alu.sv */
// Pipelined signed fixed-point ALU with a bit-per-stage restoring divider.
//
//  port     dir  handshake      payload
//  req_if   in   valid/ready    opcode, operand_a, operand_b
//  rsp_if   out  valid/ready    result_value, compare_true, error_flag
//
// Every request passes all stages, and the divider resolves one quotient bit
// per stage.
// One request enters per cycle and one response leaves per cycle while rsp_if.ready is high.
// Each stage advances when it is empty or the next one advances, so a stalled
// response lets bubbles in front of it fill; no request is lost or repeated.
// Synchronous reset empties the pipeline; payload registers are not reset.
module fixed_point_alu import fpalu_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   fpalu_req_if.sink    req_if,
   fpalu_rsp_if.source  rsp_if
);

   localparam int NW   = DATA_W + FRAC_BITS;
   localparam int LAST = NW + 3;
   localparam logic [2*DATA_W-1:0] HALF     = (64'd1 << FRAC_BITS) >> 1;
   localparam logic [2*DATA_W-1:0] MUL_POS  = 64'h0000_0000_7fff_ffff;
   localparam logic [2*DATA_W-1:0] MUL_NEG  = 64'h0000_0000_8000_0000;
   localparam logic [NW:0]         DIV_POS  = (NW+1)'(MAX_RAW);
   localparam logic [NW:0]         DIV_NEG  = (NW+1)'(MIN_RAW);

   typedef struct packed {
      opcode_type        op;
      logic [DATA_W-1:0] res;
      logic              cmp;
      logic              err;
      logic              neg;
      logic              dz;
      logic [DATA_W-1:0] den;
      logic [DATA_W-1:0] rem;
      logic [NW-1:0]     nq;
   } stage_type;

   logic [LAST:0]            vld_ff;
   logic [LAST:0]            adv;

   opcode_type               op1_ff;
   logic signed [DATA_W-1:0] a1_ff;
   logic signed [DATA_W-1:0] b1_ff;

   stage_type                st2_ff, st2_in;
   logic signed [2*DATA_W-1:0] prod2_ff;

   stage_type                st3_in;
   stage_type                dstg_ff [NW+1];
   stage_type                dstg_in [NW+1];

   logic [DATA_W-1:0]        out_res_ff, out_res_in;
   logic                     out_cmp_ff, out_cmp_in;
   logic                     out_err_ff, out_err_in;

   // Ready chain: a stage moves when it is empty or its successor moves
   always_comb begin
      adv[LAST] = !vld_ff[LAST] || rsp_if.ready;
      for (int i = LAST - 1; i >= 0; i--) begin
         adv[i] = !vld_ff[i] || adv[i+1];
      end
   end

   assign req_if.ready = adv[0];

   // Valid bits travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (adv[0]) begin
            vld_ff[0] <= req_if.valid;
         end
         for (int i = 1; i <= LAST; i++) begin
            if (adv[i]) begin
               vld_ff[i] <= vld_ff[i-1];
            end
         end
      end
   end

   // Stage 2: simple results, product, divider setup
   always_comb begin
      logic [DATA_W:0]        sum33;
      logic signed [NW-1:0]   ax;
      logic signed [NW-1:0]   shl;
      logic [NW-DATA_W:0]     hi;
      logic [DATA_W-1:0]      abs_a;
      logic [DATA_W-1:0]      abs_b;

      st2_in     = '0;
      st2_in.op  = op1_ff;
      sum33      = '0;
      ax         = NW'(a1_ff);
      shl        = ax <<< FRAC_BITS;
      hi         = shl[NW-1:DATA_W-1];
      abs_a      = a1_ff[DATA_W-1] ? (~a1_ff + 1'b1) : a1_ff;
      abs_b      = b1_ff[DATA_W-1] ? (~b1_ff + 1'b1) : b1_ff;

      case (op1_ff)
         OP_ADD: begin
            sum33 = {a1_ff[DATA_W-1], a1_ff} + {b1_ff[DATA_W-1], b1_ff};
            {st2_in.err, st2_in.res} = sat_sum(sum33);
         end
         OP_SUB: begin
            sum33 = {a1_ff[DATA_W-1], a1_ff} - {b1_ff[DATA_W-1], b1_ff};
            {st2_in.err, st2_in.res} = sat_sum(sum33);
         end
         OP_INC: begin
            sum33 = {a1_ff[DATA_W-1], a1_ff} + (DATA_W+1)'(1);
            {st2_in.err, st2_in.res} = sat_sum(sum33);
         end
         OP_DEC: begin
            sum33 = {a1_ff[DATA_W-1], a1_ff} - (DATA_W+1)'(1);
            {st2_in.err, st2_in.res} = sat_sum(sum33);
         end
         OP_GT:  st2_in.cmp = (a1_ff >  b1_ff);
         OP_LT:  st2_in.cmp = (a1_ff <  b1_ff);
         OP_GE:  st2_in.cmp = (a1_ff >= b1_ff);
         OP_LE:  st2_in.cmp = (a1_ff <= b1_ff);
         OP_NE:  st2_in.cmp = (a1_ff != b1_ff);
         OP_EQ:  st2_in.cmp = (a1_ff == b1_ff);
         OP_MIN: st2_in.res = (a1_ff <= b1_ff) ? a1_ff : b1_ff;
         OP_MAX: st2_in.res = (a1_ff >= b1_ff) ? a1_ff : b1_ff;
         OP_TO_INT: st2_in.res = a1_ff >>> FRAC_BITS;
         OP_FROM_INT: begin
            if ((&hi) || !(|hi)) begin
               st2_in.res = shl[DATA_W-1:0];
            end else begin
               st2_in.err = 1'b1;
               st2_in.res = a1_ff[DATA_W-1] ? MIN_RAW : MAX_RAW;
            end
         end
         default: begin
            // multiply and divide finish in later stages
            st2_in.res = '0;
         end
      endcase

      st2_in.neg = a1_ff[DATA_W-1] ^ b1_ff[DATA_W-1];
      st2_in.dz  = (b1_ff == '0);
      st2_in.den = abs_b;
      st2_in.rem = '0;
      st2_in.nq  = NW'(abs_a) << FRAC_BITS;
   end

   // Stage 3: round and clamp the product
   always_comb begin
      logic [2*DATA_W-1:0] mag;
      logic [2*DATA_W-1:0] q;
      logic                pn;

      st3_in = st2_ff;
      pn  = prod2_ff[2*DATA_W-1];
      mag = pn ? (~prod2_ff + 1'b1) : prod2_ff;
      q   = (mag + HALF) >> FRAC_BITS;
      if (st2_ff.op == OP_MUL) begin
         if (pn) begin
            if (q > MUL_NEG) begin
               st3_in.err = 1'b1;
               st3_in.res = MIN_RAW;
            end else begin
               st3_in.res = ~q[DATA_W-1:0] + 1'b1;
            end
         end else begin
            if (q > MUL_POS) begin
               st3_in.err = 1'b1;
               st3_in.res = MAX_RAW;
            end else begin
               st3_in.res = q[DATA_W-1:0];
            end
         end
      end
   end

   // Divider: one restoring step per stage, quotient bits shift into nq
   always_comb begin
      logic [DATA_W:0] trial;
      logic            ge;

      dstg_in[0] = st3_in;
      for (int k = 0; k < NW; k++) begin
         dstg_in[k+1] = dstg_ff[k];
         trial = {dstg_ff[k].rem, dstg_ff[k].nq[NW-1]};
         ge    = (trial >= {1'b0, dstg_ff[k].den});
         dstg_in[k+1].rem = ge ? DATA_W'(trial - {1'b0, dstg_ff[k].den})
                               : trial[DATA_W-1:0];
         dstg_in[k+1].nq  = {dstg_ff[k].nq[NW-2:0], ge};
      end
   end

   // Last stage: round the quotient, clamp, select the response
   always_comb begin
      logic          rup;
      logic [NW:0]   qr;

      rup        = ({dstg_ff[NW].rem, 1'b0} >= {1'b0, dstg_ff[NW].den});
      qr         = {1'b0, dstg_ff[NW].nq} + (NW+1)'(rup);
      out_res_in = dstg_ff[NW].res;
      out_cmp_in = dstg_ff[NW].cmp;
      out_err_in = dstg_ff[NW].err;
      if (dstg_ff[NW].op == OP_DIV) begin
         out_err_in = 1'b0;
         if (dstg_ff[NW].dz) begin
            out_res_in = '0;
            out_err_in = 1'b1;
         end else if (dstg_ff[NW].neg) begin
            if (qr > DIV_NEG) begin
               out_res_in = MIN_RAW;
               out_err_in = 1'b1;
            end else begin
               out_res_in = ~qr[DATA_W-1:0] + 1'b1;
            end
         end else begin
            if (qr > DIV_POS) begin
               out_res_in = MAX_RAW;
               out_err_in = 1'b1;
            end else begin
               out_res_in = qr[DATA_W-1:0];
            end
         end
      end
   end

   // Payload registers advance with their stage
   always_ff @(posedge clock) begin
      if (adv[0]) begin
         op1_ff <= opcode_type'(req_if.opcode);
         a1_ff  <= req_if.operand_a;
         b1_ff  <= req_if.operand_b;
      end
      if (adv[1]) begin
         st2_ff   <= st2_in;
         prod2_ff <= (2*DATA_W)'(a1_ff) * (2*DATA_W)'(b1_ff);
      end
      for (int k = 0; k <= NW; k++) begin
         if (adv[k+2]) begin
            dstg_ff[k] <= dstg_in[k];
         end
      end
      if (adv[LAST]) begin
         out_res_ff <= out_res_in;
         out_cmp_ff <= out_cmp_in;
         out_err_ff <= out_err_in;
      end
   end

   assign rsp_if.valid        = vld_ff[LAST];
   assign rsp_if.result_value = out_res_ff;
   assign rsp_if.compare_true = out_cmp_ff;
   assign rsp_if.error_flag   = out_err_ff;

endmodule

/* sv/fpalu_checker.sv */
// Port-level checks for the fixed-point ALU, bound to the top level.
module fpalu_checker import fpalu_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [DATA_W-1:0] rsp_result_value,
   input logic              rsp_compare_true,
   input logic              rsp_error_flag
);

   // Hold a stalled response
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_value)
         && $stable(rsp_compare_true) && $stable(rsp_error_flag))
      else $error("stalled response changed");

   // A true compare carries a zero value and no error
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_compare_true |-> rsp_result_value == '0 && !rsp_error_flag)
      else $error("compare response with value or error");

   // Reset drops every response in flight
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // An empty output stage never blocks requests
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request blocked with empty output");

endmodule

bind fixed_point_alu fpalu_checker u_fpalu_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_if.valid),
   .req_ready        (req_if.ready),
   .rsp_valid        (rsp_if.valid),
   .rsp_ready        (rsp_if.ready),
   .rsp_result_value (rsp_if.result_value),
   .rsp_compare_true (rsp_if.compare_true),
   .rsp_error_flag   (rsp_if.error_flag)
);
